// File: src/ppc_pkg.sv
// Shared types, constants and a helper function of the PID position controller.
`default_nettype none
package ppc_pkg;

    localparam int DATA_W  = 32;
    localparam int LIMIT_W = 31;
    localparam int INT_W   = 18;
    localparam int CIDX_W  = 8;
    localparam int Q_ONE   = 65536;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

    typedef enum logic [CIDX_W-1:0] {
        CFG_GAIN_P       = 8'd0,
        CFG_GAIN_I       = 8'd1,
        CFG_GAIN_D       = 8'd2,
        CFG_OUTPUT_LIMIT = 8'd3
    } t_cfg_reg;

    // Saturates a 33-bit signed difference to the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] res;
        if (v[DATA_W] != v[DATA_W-1]) begin
            res = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: src/ppc_if.sv
// Handshake channel interfaces of the PID position controller.
`default_nettype none
interface ppc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [ppc_pkg::DATA_W-1:0]   measured;
    logic signed [ppc_pkg::DATA_W-1:0]   setpoint;

    modport source (output valid, output measured, output setpoint, input ready);
    modport sink   (input valid, input measured, input setpoint, output ready);
endinterface

interface ppc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ppc_pkg::DATA_W-1:0]   drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

interface ppc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ppc_pkg::CIDX_W-1:0]          index;
    logic [ppc_pkg::DATA_W-1:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: src/pid_position_controller.sv
// PID position controller: signed Q16.16 error, clamped integral and drive.
//
// A request on i_req carries a measured value and a setpoint. Each request
// yields exactly one drive value on o_rsp, in request order. The block is a
// five-register pipeline (input, error, integral and difference, the three
// gain products, drive), with the drive value held in the last register,
// and one request is taken every cycle as long as o_rsp is drained.
// The integral and the previous error are fed back inside the error stage,
// which is what allows back-to-back requests.
// Each stage moves on when the next one is empty or moving, so a stall on
// o_rsp fills the empty stages first and then drops i_req.ready.
// Gains and the output limit are written over i_cfg, which is always ready;
// they are meant to be written while no request is in flight.
// A synchronous reset empties the pipeline, clears the integral and the
// previous error, sets the gains to zero and the limit to its maximum.
`default_nettype none
module pid_position_controller (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ppc_in_if.sink      i_req,
    ppc_cfg_if.sink     i_cfg,
    ppc_out_if.source   o_rsp
);

    localparam int DW = ppc_pkg::DATA_W;
    localparam int IW = ppc_pkg::INT_W;
    localparam int LW = ppc_pkg::LIMIT_W;
    localparam int PI_W = DW + IW;          // gain times integral
    localparam int TW = 2*DW - 16;          // P and D terms after the shift
    localparam int TIW = PI_W - 17;         // I term after the shift
    localparam int SW = TW + 2;             // sum of the three terms

    localparam logic signed [DW:0] IMAX = (DW+1)'(ppc_pkg::Q_ONE);
    localparam logic signed [DW:0] IMIN = -IMAX;

    // Configuration registers.
    logic signed [DW-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [LW-1:0]        r_limit;

    // Pipeline valid bits.
    logic r_v1, r_v2, r_v3, r_v4, r_vo;
    logic rdy_o, rdy_4, rdy_3, rdy_2, rdy_1;

    // Stage payloads and controller state.
    logic signed [DW-1:0]   r_meas, r_set;
    logic signed [DW-1:0]   r_err2;
    logic signed [IW-1:0]   r_int;
    logic signed [DW-1:0]   r_prev;
    logic signed [DW-1:0]   r_err3, r_diff3;
    logic signed [IW-1:0]   r_int3;
    logic signed [2*DW-1:0] r_prod_p, r_prod_d;
    logic signed [PI_W-1:0] r_prod_i;
    logic signed [DW-1:0]   r_drive;

    logic signed [DW-1:0]   n_err2;
    logic signed [DW:0]     w_isum;
    logic signed [IW-1:0]   n_int;
    logic signed [DW-1:0]   n_diff;
    logic signed [2*DW-1:0] n_prod_p, n_prod_d;
    logic signed [PI_W-1:0] n_prod_i;
    logic signed [TW-1:0]   w_tp, w_td;
    logic signed [TIW-1:0]  w_ti;
    logic signed [SW-1:0]   w_sum, w_lim_hi, w_lim_lo;
    logic signed [DW-1:0]   n_drive;

    assign rdy_o = !r_vo || o_rsp.ready;
    assign rdy_4 = !r_v4 || rdy_o;
    assign rdy_3 = !r_v3 || rdy_4;
    assign rdy_2 = !r_v2 || rdy_3;
    assign rdy_1 = !r_v1 || rdy_2;

    assign i_req.ready = rdy_1;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_vo;
    assign o_rsp.drive = r_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_limit  <= ppc_pkg::LIMIT_RESET;
        end else if (i_cfg.valid) begin
            case (ppc_pkg::t_cfg_reg'(i_cfg.index))
                ppc_pkg::CFG_GAIN_P:       r_gain_p <= i_cfg.data;
                ppc_pkg::CFG_GAIN_I:       r_gain_i <= i_cfg.data;
                ppc_pkg::CFG_GAIN_D:       r_gain_d <= i_cfg.data;
                ppc_pkg::CFG_OUTPUT_LIMIT: r_limit  <= i_cfg.data[LW-1:0];
                default: ;
            endcase
        end
    end

    // Error stage arithmetic.
    always_comb begin
        n_err2 = ppc_pkg::sat32((DW+1)'(r_set) - (DW+1)'(r_meas));
    end

    // Integral and difference, against the state left by the previous request.
    always_comb begin
        w_isum = (DW+1)'(r_int) + (DW+1)'(r_err2);
        if (w_isum > IMAX) begin
            n_int = IMAX[IW-1:0];
        end else if (w_isum < IMIN) begin
            n_int = IMIN[IW-1:0];
        end else begin
            n_int = w_isum[IW-1:0];
        end
        n_diff = ppc_pkg::sat32((DW+1)'(r_err2) - (DW+1)'(r_prev));
    end

    always_comb begin
        n_prod_p = (2*DW)'(r_gain_p) * (2*DW)'(r_err3);
        n_prod_i = PI_W'(r_gain_i) * PI_W'(r_int3);
        n_prod_d = (2*DW)'(r_gain_d) * (2*DW)'(r_diff3);
    end

    // Taking the upper bits of a product is a shift that rounds toward minus infinity.
    always_comb begin
        w_tp     = r_prod_p[2*DW-1:16];
        w_ti     = r_prod_i[PI_W-1:17];
        w_td     = r_prod_d[2*DW-1:16];
        w_sum    = SW'(w_tp) + SW'(w_ti) + SW'(w_td);
        w_lim_hi = SW'({1'b0, r_limit});
        w_lim_lo = -w_lim_hi;
        if (w_sum > w_lim_hi) begin
            n_drive = w_lim_hi[DW-1:0];
        end else if (w_sum < w_lim_lo) begin
            n_drive = w_lim_lo[DW-1:0];
        end else begin
            n_drive = w_sum[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_vo   <= 1'b0;
            r_int  <= '0;
            r_prev <= '0;
        end else begin
            if (rdy_1) begin
                r_v1 <= i_req.valid;
            end
            if (rdy_2) begin
                r_v2 <= r_v1;
            end
            if (rdy_3) begin
                r_v3 <= r_v2;
            end
            if (rdy_4) begin
                r_v4 <= r_v3;
            end
            if (rdy_o) begin
                r_vo <= r_v4;
            end
            // The state moves only when a request leaves the error stage.
            if (r_v2 && rdy_3) begin
                r_int  <= n_int;
                r_prev <= r_err2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_1 && i_req.valid) begin
            r_meas <= i_req.measured;
            r_set  <= i_req.setpoint;
        end
        if (rdy_2 && r_v1) begin
            r_err2 <= n_err2;
        end
        if (rdy_3 && r_v2) begin
            r_err3  <= r_err2;
            r_int3  <= n_int;
            r_diff3 <= n_diff;
        end
        if (rdy_4 && r_v3) begin
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
        end
        if (rdy_o && r_v4) begin
            r_drive <= n_drive;
        end
    end

`ifndef SYNTHESIS
    a_int_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((DW+1)'(r_int) <= IMAX) && ((DW+1)'(r_int) >= IMIN))
        else $error("integral left the range of plus or minus one");

    a_req_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_v1)
        else $error("accepted request did not reach the input stage");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v1 && !r_v2 && !r_v3 && !r_v4 && !r_vo) |-> i_req.ready)
        else $error("empty pipeline refused a request");

    a_state_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && rdy_3) |=> (r_prev == $past(r_err2)))
        else $error("previous error not updated by a leaving request");
`endif

endmodule
`default_nettype wire
